[design/cdbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdbf_pkg
// Shared types and constants for the clock divider best-fit search core.
// ----------------------------------------------------------------------------
package cdbf_pkg;

    // search space
    localparam int SOURCE_COUNT = 3;
    localparam int POW2_STEPS   = 4;
    localparam int LINEAR_STEPS = 16;

    // rate and field widths
    localparam int RATE_W      = 32;
    localparam int SRC_FIELD_W = 2;
    localparam int EXP_FIELD_W = 2;
    localparam int LIN_FIELD_W = 4;

    // counter widths derived from the search space
    localparam int SRC_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam int N_W   = (POW2_STEPS > 1) ? $clog2(POW2_STEPS) : 1;
    localparam int M_W   = (LINEAR_STEPS > 1) ? $clog2(LINEAR_STEPS) : 1;
    localparam int D_W   = $clog2(LINEAR_STEPS + 1);

    // divider iterations, one quotient bit each
    localparam int DIV_STEPS = RATE_W;
    localparam int BIT_W     = $clog2(DIV_STEPS);

    // register word layout
    localparam int WORD_EN_BIT  = 31;
    localparam int WORD_SRC_LSB = 24;
    localparam int WORD_EXP_LSB = 8;

    // reference oscillator rate after reset
    localparam logic [RATE_W-1:0] REFERENCE_RESET = 32'd24000000;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLL0_RATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLL0_VALID     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLL1_RATE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLL1_VALID     = 3'd4;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_CMP,
        ST_FINISH
    } cdbf_state_t;

    // controller to datapath
    typedef struct packed {
        logic             start;
        logic             load;
        logic             step;
        logic             compare;
        logic             finish;
        logic [SRC_W-1:0] src;
        logic [N_W-1:0]   n;
        logic [M_W-1:0]   m;
    } cdbf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic src_valid;
        logic result_busy;
    } cdbf_status_t;

endpackage
`default_nettype wire

[design/cdbf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdbf channel interfaces
// Request channel (target rate) and result channel (chosen divider setting).
// ----------------------------------------------------------------------------
interface cdbf_req_if;
    import cdbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] target_rate;

    modport source (output valid, output target_rate, input ready);
    modport sink   (input valid, input target_rate, output ready);
endinterface

interface cdbf_rsp_if;
    import cdbf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [SRC_FIELD_W-1:0] source_index;
    logic [EXP_FIELD_W-1:0] pow2_exponent;
    logic [LIN_FIELD_W-1:0] linear_divider_minus_one;
    logic [RATE_W-1:0]      achieved_rate;
    logic [RATE_W-1:0]      rate_error;
    logic [RATE_W-1:0]      clock_register_word;

    modport source (
        output valid, output found, output source_index, output pow2_exponent,
        output linear_divider_minus_one, output achieved_rate, output rate_error,
        output clock_register_word, input ready
    );
    modport sink (
        input valid, input found, input source_index, input pow2_exponent,
        input linear_divider_minus_one, input achieved_rate, input rate_error,
        input clock_register_word, output ready
    );
endinterface
`default_nettype wire

[design/cdbf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdbf_ctrl
// Sequencer for the search: walks source, exponent and linear divider,
// runs the bit-serial divider for each candidate and hands off the result.
// ----------------------------------------------------------------------------
module cdbf_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   req_valid,
    output logic                  req_ready,
    input  wire cdbf_pkg::cdbf_status_t status,
    output cdbf_pkg::cdbf_cmd_t   cmd
);
    import cdbf_pkg::*;

    localparam logic [SRC_W-1:0] S_LAST   = SRC_W'(SOURCE_COUNT - 1);
    localparam logic [N_W-1:0]   N_LAST   = N_W'(POW2_STEPS - 1);
    localparam logic [M_W-1:0]   M_LAST   = M_W'(LINEAR_STEPS - 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(DIV_STEPS - 1);

    cdbf_state_t      state_reg, state_next;
    logic [SRC_W-1:0] s_reg, s_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [M_W-1:0]   m_reg, m_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    // state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            s_reg     <= '0;
            n_reg     <= '0;
            m_reg     <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s_reg     <= s_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            bit_reg   <= bit_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        bit_next    = bit_reg;
        req_ready   = 1'b0;
        cmd.start   = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.compare = 1'b0;
        cmd.finish  = 1'b0;
        cmd.src     = s_reg;
        cmd.n       = n_reg;
        cmd.m       = m_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    s_next     = '0;
                    n_next     = '0;
                    m_next     = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // scan ends at the first unusable source
                if (status.src_valid)
                begin
                    cmd.load   = 1'b1;
                    bit_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_LAST)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_LOAD;
                if (m_reg == M_LAST)
                begin
                    m_next = '0;
                    if (n_reg == N_LAST)
                    begin
                        n_next = '0;
                        if (s_reg == S_LAST)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            s_next = s_reg + SRC_W'(1);
                        end
                    end
                    else
                    begin
                        n_next = n_reg + N_W'(1);
                    end
                end
                else
                begin
                    m_next = m_reg + M_W'(1);
                end
            end
            ST_FINISH:
            begin
                // wait for the result register to free up
                if (!status.result_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/cdbf_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdbf_datapath
// Configuration registers, source select, bit-serial restoring divider,
// best-fit tracking and the result register.
// ----------------------------------------------------------------------------
module cdbf_datapath (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire  [cdbf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [cdbf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire  [cdbf_pkg::RATE_W-1:0]          target_rate,
    input  wire  cdbf_pkg::cdbf_cmd_t            cmd,
    output cdbf_pkg::cdbf_status_t               status,
    input  wire                                  rsp_ready,
    output logic                                 rsp_valid,
    output logic                                 found,
    output logic [cdbf_pkg::SRC_FIELD_W-1:0]     source_index,
    output logic [cdbf_pkg::EXP_FIELD_W-1:0]     pow2_exponent,
    output logic [cdbf_pkg::LIN_FIELD_W-1:0]     linear_divider_minus_one,
    output logic [cdbf_pkg::RATE_W-1:0]          achieved_rate,
    output logic [cdbf_pkg::RATE_W-1:0]          rate_error,
    output logic [cdbf_pkg::RATE_W-1:0]          clock_register_word
);
    import cdbf_pkg::*;

    // configuration
    logic [RATE_W-1:0] reference_rate_reg;
    logic [RATE_W-1:0] pll0_rate_reg;
    logic              pll0_valid_reg;
    logic [RATE_W-1:0] pll1_rate_reg;
    logic              pll1_valid_reg;

    // search state
    logic [RATE_W-1:0] target_reg;
    logic [RATE_W-1:0] best_err_reg;
    logic [RATE_W-1:0] best_rate_reg;
    logic [SRC_W-1:0]  best_src_reg;
    logic [N_W-1:0]    best_n_reg;
    logic [M_W-1:0]    best_m_reg;
    logic              found_reg;

    // divider
    logic [RATE_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [D_W-1:0]    divisor_reg;
    logic [D_W:0]      trial;
    logic              trial_ge;

    // result register
    logic              rsp_valid_reg;
    logic              rsp_found_reg;
    logic [SRC_FIELD_W-1:0] rsp_src_reg;
    logic [EXP_FIELD_W-1:0] rsp_exp_reg;
    logic [LIN_FIELD_W-1:0] rsp_lin_reg;
    logic [RATE_W-1:0] rsp_rate_reg;
    logic [RATE_W-1:0] rsp_err_reg;
    logic [RATE_W-1:0] rsp_word_reg;

    logic [RATE_W-1:0] sel_rate;
    logic              src_ok;
    logic [1:0]        src_sel;
    logic [RATE_W-1:0] cand_err;
    logic [7:0]        src_wide, n_wide, m_wide;
    logic [SRC_FIELD_W-1:0] src_f;
    logic [EXP_FIELD_W-1:0] exp_f;
    logic [LIN_FIELD_W-1:0] lin_f;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_rate_reg <= REFERENCE_RESET;
            pll0_rate_reg      <= '0;
            pll0_valid_reg     <= 1'b0;
            pll1_rate_reg      <= '0;
            pll1_valid_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REFERENCE_RATE: reference_rate_reg <= cfg_data[RATE_W-1:0];
                REG_PLL0_RATE:      pll0_rate_reg      <= cfg_data[RATE_W-1:0];
                REG_PLL0_VALID:     pll0_valid_reg     <= cfg_data[0];
                REG_PLL1_RATE:      pll1_rate_reg      <= cfg_data[RATE_W-1:0];
                REG_PLL1_VALID:     pll1_valid_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // source select, plls run at half their configured rate
    assign src_sel = 2'(cmd.src);
    always_comb
    begin
        unique case (src_sel)
            2'd0:
            begin
                sel_rate = reference_rate_reg;
                src_ok   = 1'b1;
            end
            2'd1:
            begin
                sel_rate = pll0_rate_reg >> 1;
                src_ok   = pll0_valid_reg;
            end
            2'd2:
            begin
                sel_rate = pll1_rate_reg >> 1;
                src_ok   = pll1_valid_reg;
            end
            default:
            begin
                sel_rate = '0;
                src_ok   = 1'b0;
            end
        endcase
    end

    assign status.src_valid   = src_ok;
    assign status.result_busy = rsp_valid_reg && !rsp_ready;

    // one restoring division step
    assign trial    = {rem_reg, quo_reg[RATE_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});
    assign rem_next = trial_ge ? D_W'(trial - {1'b0, divisor_reg}) : D_W'(trial);
    assign quo_next = {quo_reg[RATE_W-2:0], trial_ge};

    // candidate error against the target
    assign cand_err = (quo_reg > target_reg) ? (quo_reg - target_reg)
                                             : (target_reg - quo_reg);

    // divider and best-fit registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg     <= sel_rate >> cmd.n;
            rem_reg     <= '0;
            divisor_reg <= D_W'(cmd.m) + D_W'(1);
        end
        else if (cmd.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end

        if (cmd.start)
        begin
            target_reg   <= target_rate;
            best_err_reg <= target_rate;
        end
        else if (cmd.compare && (cand_err < best_err_reg))
        begin
            best_err_reg  <= cand_err;
            best_rate_reg <= quo_reg;
            best_src_reg  <= cmd.src;
            best_n_reg    <= cmd.n;
            best_m_reg    <= cmd.m;
        end
    end

    // found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.compare && (cand_err < best_err_reg))
        begin
            found_reg <= 1'b1;
        end
    end

    // chosen indexes masked to their field widths
    assign src_wide = 8'(best_src_reg);
    assign n_wide   = 8'(best_n_reg);
    assign m_wide   = 8'(best_m_reg);
    assign src_f    = src_wide[SRC_FIELD_W-1:0];
    assign exp_f    = n_wide[EXP_FIELD_W-1:0];
    assign lin_f    = m_wide[LIN_FIELD_W-1:0];

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_found_reg <= found_reg;
            rsp_err_reg   <= best_err_reg;
            if (found_reg)
            begin
                rsp_src_reg  <= src_f;
                rsp_exp_reg  <= exp_f;
                rsp_lin_reg  <= lin_f;
                rsp_rate_reg <= best_rate_reg;
                rsp_word_reg <= (RATE_W'(1) << WORD_EN_BIT)
                              | (RATE_W'(src_f) << WORD_SRC_LSB)
                              | (RATE_W'(exp_f) << WORD_EXP_LSB)
                              | RATE_W'(lin_f);
            end
            else
            begin
                rsp_src_reg  <= '0;
                rsp_exp_reg  <= '0;
                rsp_lin_reg  <= '0;
                rsp_rate_reg <= '0;
                rsp_word_reg <= '0;
            end
        end
    end

    assign rsp_valid                = rsp_valid_reg;
    assign found                    = rsp_found_reg;
    assign source_index             = rsp_src_reg;
    assign pow2_exponent            = rsp_exp_reg;
    assign linear_divider_minus_one = rsp_lin_reg;
    assign achieved_rate            = rsp_rate_reg;
    assign rate_error               = rsp_err_reg;
    assign clock_register_word      = rsp_word_reg;

endmodule
`default_nettype wire

[design/clock_divider_best_fit_search_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clock_divider_best_fit_search_core
// Finds the source, power-of-two and linear divider whose rate lies closest
// to a requested clock rate.
// ----------------------------------------------------------------------------
//
//   port      | role          | payload
//   ----------+---------------+-------------------------------------------
//   request   | in, ready/val | target_rate
//   result    | out, rdy/val  | found, source_index, pow2_exponent,
//             |               | linear_divider_minus_one, achieved_rate,
//             |               | rate_error, clock_register_word
//   cfg_*     | write only    | register index and data, no read-back
//
// each candidate is one load, a run of the one-bit-per-cycle divider and one
// compare; a full scan covers 192 candidates.
// the scan ends early at the first source that is not valid.
// one request is worked on at a time; request.ready is high only while idle.
// a finished result sits in the output register while the next request runs;
// the search waits at its end only if that register is still occupied.
// reset restores the configuration registers and empties the result register.
// ----------------------------------------------------------------------------
module clock_divider_best_fit_search_core (
    input  wire                               clk,
    input  wire                               rst_n,
    cdbf_req_if.sink                          request,
    cdbf_rsp_if.source                        result,
    input  wire                               cfg_write,
    input  wire [cdbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [cdbf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cdbf_pkg::*;

    cdbf_cmd_t    cmd;
    cdbf_status_t status;
    logic         req_ready;
    logic         rsp_valid;

    // sequencer
    cdbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // divider, best-fit tracking and result register
    cdbf_datapath u_datapath (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cfg_write                (cfg_write),
        .cfg_index                (cfg_index),
        .cfg_data                 (cfg_data),
        .target_rate              (request.target_rate),
        .cmd                      (cmd),
        .status                   (status),
        .rsp_ready                (result.ready),
        .rsp_valid                (rsp_valid),
        .found                    (result.found),
        .source_index             (result.source_index),
        .pow2_exponent            (result.pow2_exponent),
        .linear_divider_minus_one (result.linear_divider_minus_one),
        .achieved_rate            (result.achieved_rate),
        .rate_error               (result.rate_error),
        .clock_register_word      (result.clock_register_word)
    );

    assign request.ready = req_ready;
    assign result.valid  = rsp_valid;

endmodule
`default_nettype wire

[design/cdbf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdbf_checker
// Port-level checks for the clock divider best-fit search core.
// ----------------------------------------------------------------------------
module cdbf_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        req_valid,
    input wire        req_ready,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire        found,
    input wire [1:0]  source_index,
    input wire [1:0]  pow2_exponent,
    input wire [3:0]  linear_divider_minus_one,
    input wire [31:0] achieved_rate,
    input wire [31:0] rate_error,
    input wire [31:0] clock_register_word
);

    // a stalled result keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(clock_register_word)
            && $stable(rate_error) && $stable(achieved_rate) && $stable(found))
        else $error("result changed while stalled");

    // an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a search runs");

    // register word agrees with the setting fields
    a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> clock_register_word[31]
            && clock_register_word[25:24] == source_index
            && clock_register_word[9:8] == pow2_exponent
            && clock_register_word[3:0] == linear_divider_minus_one
            && source_index != 2'd3)
        else $error("register word does not match the chosen setting");

    // no setting found gives an empty result
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> clock_register_word == 32'd0
            && achieved_rate == 32'd0 && source_index == 2'd0
            && linear_divider_minus_one == 4'd0)
        else $error("empty result carries a setting");

endmodule

bind clock_divider_best_fit_search_core cdbf_checker u_cdbf_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .req_valid                (request.valid),
    .req_ready                (request.ready),
    .rsp_valid                (result.valid),
    .rsp_ready                (result.ready),
    .found                    (result.found),
    .source_index             (result.source_index),
    .pow2_exponent            (result.pow2_exponent),
    .linear_divider_minus_one (result.linear_divider_minus_one),
    .achieved_rate            (result.achieved_rate),
    .rate_error               (result.rate_error),
    .clock_register_word      (result.clock_register_word)
);
`default_nettype wire
